### src/srhp_pkg.sv
// Shared types and constants for the stepper ramp and homing pulser.
package srhp_pkg;

  localparam int unsigned DELAY_W = 16;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned HITS_W  = 16;

  localparam logic [1:0] REG_ACCEL_STEPS = 2'd0;
  localparam logic [1:0] REG_DECEL_STEPS = 2'd1;
  localparam logic [1:0] REG_SHORT_DELAY = 2'd2;
  localparam logic [1:0] REG_LONG_DELAY  = 2'd3;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [DELAY_W-1:0] SHORT_DELAY_RESET = 16'd10;
  localparam logic [DELAY_W-1:0] LONG_DELAY_RESET  = 16'd10;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_DIV_LD  = 10'b00_0000_0010,
    ST_DIV_RUN = 10'b00_0000_0100,
    ST_TK1     = 10'b00_0000_1000,
    ST_TK2     = 10'b00_0001_0000,
    ST_TK3     = 10'b00_0010_0000,
    ST_TK4     = 10'b00_0100_0000,
    ST_TK5     = 10'b00_1000_0000,
    ST_OUT     = 10'b01_0000_0000,
    ST_SPARE   = 10'b10_0000_0000
  } state_t;

endpackage

### src/stepper_ramp_homing_pulser.sv
// Stepper move pulser: trapezoidal delay ramp, limit-switch homing, position tracking.
// One result per item. With the ramp off, a start item goes straight to the output; with the ramp on,
// the two ramp increments come from one shared restoring divider, one quotient bit per
// cycle; a zero ramp step count register skips its division. A tick item runs through a
// short compare/update sequence of states, cut short when a limit hit stops the move;
// a tick with no move running goes straight to the output.
// The output register lets the next item be accepted while a result waits.
module stepper_ramp_homing_pulser #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic        in_move_up,
  input  logic [31:0] in_step_count,
  input  logic [31:0] in_top_height,
  input  logic [15:0] in_allowed_hits,
  input  logic        in_no_switch,
  input  logic        in_limit_hit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_pulse,
  output logic [15:0] out_delay_us,
  output logic [31:0] out_position,
  output logic        out_homed,
  output logic        out_done_res
);

  localparam int unsigned DW  = srhp_pkg::DELAY_W + FRACTION_BITS;
  localparam int unsigned CW  = $clog2(DW);

  srhp_pkg::state_t state_r, state_nxt;

  logic [15:0] accel_steps_r, decel_steps_r, short_delay_r, long_delay_r;

  logic [31:0] position_r;
  logic        homed_r;
  logic [DW-1:0] cur_delay_r;
  logic [31:0] step_index_r;
  logic [31:0] steps_total_r;
  logic [31:0] top_r;
  logic [15:0] hits_left_r;
  logic        dir_up_r;
  logic        ramp_en_r;
  logic [DW-1:0] accel_inc_r, decel_inc_r;
  logic [15:0] last_delay_r;
  logic        move_active_r;

  logic        hit_r;
  logic        res_pulse_r;
  logic        driving_r, accel_ph_r, decel_ph_r, above_short_r;
  logic [31:0] decel_from_r;

  logic [DW-1:0] span_r;
  logic [DW-1:0] quo_r;
  logic [15:0]   rem_r;
  logic [CW-1:0] cnt_r;
  logic          div_sel_r;

  logic          out_valid_r;
  logic          out_pulse_r;
  logic [15:0]   out_delay_r;
  logic [31:0]   out_position_r;
  logic          out_homed_r;
  logic          out_done_r;

  logic          in_fire;
  logic          out_load;
  logic [15:0]   divisor;
  logic [16:0]   trial;
  logic [16:0]   trial_sub;
  logic          q_bit;
  logic [DW-1:0] quo_nxt;
  logic [DW-1:0] short_fx;
  logic [DW:0]   dsum;
  logic [DW:0]   asub;
  logic [DW-1:0] cur_delay_nxt;
  logic          stop_hit;
  logic [31:0]   pos_base;

  assign in_ready  = (state_r == srhp_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == srhp_pkg::ST_OUT) && (!out_valid_r || out_ready);

  assign divisor   = div_sel_r ? decel_steps_r : accel_steps_r;
  assign trial     = {rem_r, quo_r[DW-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign q_bit     = !trial_sub[16];
  assign quo_nxt   = {quo_r[DW-2:0], q_bit};

  assign short_fx  = {short_delay_r, {FRACTION_BITS{1'b0}}};
  assign dsum      = {1'b0, cur_delay_r} + {1'b0, decel_inc_r};
  assign asub      = {1'b0, cur_delay_r} - {1'b0, accel_inc_r};

  always_comb begin
    cur_delay_nxt = cur_delay_r;
    if (accel_ph_r) begin
      if (above_short_r) begin
        cur_delay_nxt = asub[DW] ? '0 : asub[DW-1:0];
      end else begin
        cur_delay_nxt = short_fx;
      end
    end else if (decel_ph_r) begin
      if (dsum[DW] || (&dsum[DW-1:FRACTION_BITS] && |dsum[FRACTION_BITS-1:0])) begin
        cur_delay_nxt = {{srhp_pkg::DELAY_W{1'b1}}, {FRACTION_BITS{1'b0}}};
      end else begin
        cur_delay_nxt = dsum[DW-1:0];
      end
    end
  end

  assign stop_hit = !driving_r && hit_r && (hits_left_r < 16'd2);
  assign pos_base = (!driving_r && hit_r) ? (dir_up_r ? top_r : 32'd0) : position_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srhp_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_command == srhp_pkg::CMD_START) begin
            state_nxt = (long_delay_r > short_delay_r) ? srhp_pkg::ST_DIV_LD
                                                       : srhp_pkg::ST_OUT;
          end else begin
            state_nxt = move_active_r ? srhp_pkg::ST_TK1 : srhp_pkg::ST_OUT;
          end
        end
      end
      srhp_pkg::ST_DIV_LD: begin
        if (divisor == 16'd0) begin
          state_nxt = div_sel_r ? srhp_pkg::ST_OUT : srhp_pkg::ST_DIV_LD;
        end else begin
          state_nxt = srhp_pkg::ST_DIV_RUN;
        end
      end
      srhp_pkg::ST_DIV_RUN: begin
        if (cnt_r == CW'(DW - 1)) begin
          state_nxt = div_sel_r ? srhp_pkg::ST_OUT : srhp_pkg::ST_DIV_LD;
        end
      end
      srhp_pkg::ST_TK1: state_nxt = srhp_pkg::ST_TK2;
      srhp_pkg::ST_TK2: state_nxt = srhp_pkg::ST_TK3;
      srhp_pkg::ST_TK3: state_nxt = srhp_pkg::ST_TK4;
      srhp_pkg::ST_TK4: state_nxt = stop_hit ? srhp_pkg::ST_OUT : srhp_pkg::ST_TK5;
      srhp_pkg::ST_TK5: state_nxt = srhp_pkg::ST_OUT;
      srhp_pkg::ST_OUT: begin
        if (out_load) begin
          state_nxt = srhp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srhp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= srhp_pkg::ST_IDLE;
      accel_steps_r <= '0;
      decel_steps_r <= '0;
      short_delay_r <= srhp_pkg::SHORT_DELAY_RESET;
      long_delay_r  <= srhp_pkg::LONG_DELAY_RESET;
      position_r    <= '0;
      homed_r       <= 1'b0;
      cur_delay_r   <= '0;
      step_index_r  <= '0;
      steps_total_r <= '0;
      top_r         <= '0;
      hits_left_r   <= '0;
      dir_up_r      <= 1'b0;
      ramp_en_r     <= 1'b0;
      accel_inc_r   <= '0;
      decel_inc_r   <= '0;
      last_delay_r  <= '0;
      move_active_r <= 1'b0;
      res_pulse_r   <= 1'b0;
      div_sel_r     <= 1'b0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          srhp_pkg::REG_ACCEL_STEPS: accel_steps_r <= cfg_wdata;
          srhp_pkg::REG_DECEL_STEPS: decel_steps_r <= cfg_wdata;
          srhp_pkg::REG_SHORT_DELAY: short_delay_r <= cfg_wdata;
          srhp_pkg::REG_LONG_DELAY:  long_delay_r  <= cfg_wdata;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        srhp_pkg::ST_IDLE: begin
          if (in_fire) begin
            hit_r       <= in_limit_hit;
            res_pulse_r <= 1'b0;
            if (in_command == srhp_pkg::CMD_START) begin
              dir_up_r      <= in_move_up;
              steps_total_r <= in_step_count;
              top_r         <= in_top_height;
              hits_left_r   <= in_allowed_hits;
              if (in_no_switch) begin
                homed_r <= 1'b1;
              end
              ramp_en_r     <= long_delay_r > short_delay_r;
              accel_inc_r   <= '0;
              decel_inc_r   <= '0;
              span_r        <= {long_delay_r - short_delay_r, {FRACTION_BITS{1'b0}}};
              cur_delay_r   <= {long_delay_r, {FRACTION_BITS{1'b0}}};
              last_delay_r  <= long_delay_r;
              step_index_r  <= '0;
              move_active_r <= in_step_count != 32'd0;
              div_sel_r     <= 1'b0;
            end
          end
        end
        srhp_pkg::ST_DIV_LD: begin
          if (divisor == 16'd0) begin
            if (div_sel_r) begin
              decel_inc_r <= span_r;
            end else begin
              accel_inc_r <= span_r;
              div_sel_r   <= 1'b1;
            end
          end else begin
            quo_r <= span_r;
            rem_r <= '0;
            cnt_r <= '0;
          end
        end
        srhp_pkg::ST_DIV_RUN: begin
          quo_r <= quo_nxt;
          rem_r <= q_bit ? trial_sub[15:0] : trial[15:0];
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(DW - 1)) begin
            if (div_sel_r) begin
              decel_inc_r <= quo_nxt;
            end else begin
              accel_inc_r <= quo_nxt;
              div_sel_r   <= 1'b1;
            end
          end
        end
        srhp_pkg::ST_TK1: begin
          driving_r    <= dir_up_r ? (homed_r && (position_r < top_r)) : homed_r;
          accel_ph_r   <= {1'b0, step_index_r} < ({17'd0, accel_steps_r} + 33'd1);
          decel_from_r <= steps_total_r - ({16'd0, decel_steps_r} + 32'd1);
        end
        srhp_pkg::ST_TK2: begin
          decel_ph_r    <= step_index_r > decel_from_r;
          above_short_r <= cur_delay_r > short_fx;
        end
        srhp_pkg::ST_TK3: begin
          if (driving_r) begin
            if (ramp_en_r) begin
              cur_delay_r  <= cur_delay_nxt;
              last_delay_r <= cur_delay_nxt[DW-1:FRACTION_BITS];
            end else begin
              cur_delay_r <= short_fx;
            end
          end else begin
            last_delay_r <= '0;
          end
        end
        srhp_pkg::ST_TK4: begin
          if (stop_hit) begin
            homed_r       <= 1'b1;
            position_r    <= pos_base;
            move_active_r <= 1'b0;
            res_pulse_r   <= 1'b0;
          end else begin
            if (!driving_r && hit_r) begin
              hits_left_r <= hits_left_r - 16'd1;
            end
            if (dir_up_r) begin
              position_r <= pos_base + 32'd1;
              if (!driving_r && hit_r) begin
                homed_r <= 1'b1;
              end
            end else if (pos_base != 32'd0) begin
              position_r <= pos_base - 32'd1;
              if (!driving_r && hit_r) begin
                homed_r <= 1'b1;
              end
            end else begin
              position_r <= pos_base;
              homed_r    <= 1'b0;
            end
            step_index_r <= step_index_r + 32'd1;
          end
        end
        srhp_pkg::ST_TK5: begin
          move_active_r <= step_index_r < steps_total_r;
          res_pulse_r   <= 1'b1;
        end
        srhp_pkg::ST_OUT: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pulse_r    <= res_pulse_r;
      out_delay_r    <= res_pulse_r ? last_delay_r : 16'd0;
      out_position_r <= position_r;
      out_homed_r    <= homed_r;
      out_done_r     <= !move_active_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pulse    = out_pulse_r;
  assign out_delay_us = out_delay_r;
  assign out_position = out_position_r;
  assign out_homed    = out_homed_r;
  assign out_done_res = out_done_r;

endmodule
